[design/rpi_pkg.sv]
// Shared constants for the ray/plane intersection core.
package rpi_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH     = 4;

endpackage

[design/rpi_if.sv]
// Ray and hit channel interfaces with valid/ready handshake.
interface rpi_ray_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] origin_x;
    logic signed [W-1:0] origin_y;
    logic signed [W-1:0] origin_z;
    logic signed [W-1:0] dir_x;
    logic signed [W-1:0] dir_y;
    logic signed [W-1:0] dir_z;
    logic signed [W-1:0] plane_normal_x;
    logic signed [W-1:0] plane_normal_y;
    logic signed [W-1:0] plane_normal_z;
    logic signed [W-1:0] plane_offset;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               plane_normal_x, plane_normal_y, plane_normal_z, plane_offset,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               plane_normal_x, plane_normal_y, plane_normal_z, plane_offset,
        output ready
    );
endinterface

interface rpi_hit_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic                hit;
    logic signed [W-1:0] hit_x;
    logic signed [W-1:0] hit_y;
    logic signed [W-1:0] hit_z;
    logic                saturated;

    modport source (output valid, hit, hit_x, hit_y, hit_z, saturated, input ready);
    modport sink   (input  valid, hit, hit_x, hit_y, hit_z, saturated, output ready);
endinterface

[design/rpi_front.sv]
// Front end: dot products, side/denominator and hit classification.
module rpi_front
    import rpi_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rpi_ray_if.sink                       i_ray,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit,
    output logic signed [COORD_WIDTH-1:0] o_org [3],
    output logic signed [COORD_WIDTH-1:0] o_dir [3],
    output logic [2*COORD_WIDTH+2:0]      o_side_mag,
    output logic [2*COORD_WIDTH+1:0]      o_den_mag
);
    localparam int W  = COORD_WIDTH;
    localparam int DW = 2*W+2;
    localparam int SW = 2*W+3;

    logic                r_v1, r_v2;
    logic signed [2*W-1:0] r_pd [3];
    logic signed [2*W-1:0] r_po [3];
    logic signed [W-1:0] r_off;
    logic signed [W-1:0] r_org1 [3];
    logic signed [W-1:0] r_dir1 [3];
    logic                r_hit;
    logic signed [W-1:0] r_org2 [3];
    logic signed [W-1:0] r_dir2 [3];
    logic [SW-1:0]       r_smag;
    logic [DW-1:0]       r_dmag;

    logic                ce;
    logic signed [DW-1:0] denom;
    logic signed [SW-1:0] side;
    logic signed [SW-1:0] off_al;
    logic                n_hit;

    assign ce          = !r_v2 || i_ready;
    assign i_ray.ready = ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (ce) begin
            r_v1 <= i_ray.valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_pd[0]   <= i_ray.plane_normal_x * i_ray.dir_x;
            r_pd[1]   <= i_ray.plane_normal_y * i_ray.dir_y;
            r_pd[2]   <= i_ray.plane_normal_z * i_ray.dir_z;
            r_po[0]   <= i_ray.plane_normal_x * i_ray.origin_x;
            r_po[1]   <= i_ray.plane_normal_y * i_ray.origin_y;
            r_po[2]   <= i_ray.plane_normal_z * i_ray.origin_z;
            r_off     <= i_ray.plane_offset;
            r_org1[0] <= i_ray.origin_x;
            r_org1[1] <= i_ray.origin_y;
            r_org1[2] <= i_ray.origin_z;
            r_dir1[0] <= i_ray.dir_x;
            r_dir1[1] <= i_ray.dir_y;
            r_dir1[2] <= i_ray.dir_z;
        end
    end

    always_comb begin
        off_al = SW'(r_off) <<< FRAC_BITS;
        denom  = DW'(r_pd[0]) + DW'(r_pd[1]) + DW'(r_pd[2]);
        side   = SW'(r_po[0]) + SW'(r_po[1]) + SW'(r_po[2]) + off_al;
        if (denom == '0) begin
            n_hit = 1'b0;
        end else if (side[SW-1]) begin
            n_hit = !denom[DW-1];
        end else begin
            n_hit = denom[DW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_hit  <= n_hit;
            r_org2 <= r_org1;
            r_dir2 <= r_dir1;
            r_smag <= side[SW-1] ? SW'(-side) : SW'(side);
            r_dmag <= denom[DW-1] ? DW'(-denom) : DW'(denom);
        end
    end

    assign o_valid    = r_v2;
    assign o_hit      = r_hit;
    assign o_org      = r_org2;
    assign o_dir      = r_dir2;
    assign o_side_mag = r_smag;
    assign o_den_mag  = r_dmag;
endmodule

[design/rpi_fifo.sv]
// Short queue between the front end and the back end.
module rpi_fifo
    import rpi_pkg::*;
#(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data
);
    localparam int AW = $clog2(QUEUE_DEPTH);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [AW-1:0]     r_wp, r_rp;
    logic [AW:0]       r_cnt;
    logic              push, pop;

    assign o_ready = r_cnt != (AW+1)'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

[design/rpi_back.sv]
// Back end: pipelined divider for t, coordinate multiply and saturation.
module rpi_back
    import rpi_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_hit,
    input  logic signed [COORD_WIDTH-1:0] i_org [3],
    input  logic signed [COORD_WIDTH-1:0] i_dir [3],
    input  logic [2*COORD_WIDTH+2:0]      i_side_mag,
    input  logic [2*COORD_WIDTH+1:0]      i_den_mag,
    rpi_hit_if.source                     o_res
);
    localparam int W   = COORD_WIDTH;
    localparam int DW  = 2*W+2;
    localparam int SW  = 2*W+3;
    localparam int NW  = SW+FRAC_BITS;
    localparam int CW  = (NW > DW+W) ? NW : DW+W;
    localparam int QB  = W-1;
    localparam int PW  = 2*W+1;
    localparam logic signed [PW-1:0] MAXC = (PW'(1) <<< (W-1)) - PW'(1);
    localparam logic signed [PW-1:0] MINC = -MAXC - PW'(1);

    logic                r_v    [W];
    logic                r_hit  [W];
    logic                r_over [W];
    logic [CW-1:0]       r_rem  [W];
    logic [CW-1:0]       r_den  [W];
    logic [QB-1:0]       r_q    [W];
    logic signed [W-1:0] r_org  [W][3];
    logic signed [W-1:0] r_dir  [W][3];

    logic                  r_vm, r_hitm, r_overm;
    logic signed [2*W-1:0] r_prod [3];
    logic signed [W-1:0]   r_orgm [3];

    logic                r_vo, r_hito, r_sato;
    logic signed [W-1:0] r_co [3];

    logic                ce;
    logic [CW-1:0]       num0, den0;
    logic signed [W-1:0] t_val;
    logic signed [PW-1:0] p [3];
    logic                csat [3];

    assign ce      = !r_vo || o_res.ready;
    assign o_ready = ce;
    assign num0    = CW'(i_side_mag) << FRAC_BITS;
    assign den0    = CW'(i_den_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (ce) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_hit[0]  <= i_hit;
            r_over[0] <= num0 >= (den0 << (W-1));
            r_rem[0]  <= num0;
            r_den[0]  <= den0;
            r_q[0]    <= '0;
            r_org[0]  <= i_org;
            r_dir[0]  <= i_dir;
        end
    end

    for (genvar i = 0; i < W-1; i++) begin : g_div
        localparam int K = W-2-i;
        logic [CW-1:0] shd;
        logic          ge;
        logic [QB-1:0] n_q;

        always_comb begin
            shd    = r_den[i] << K;
            ge     = r_rem[i] >= shd;
            n_q    = r_q[i];
            n_q[K] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (ce) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_hit[i+1]  <= r_hit[i];
                r_over[i+1] <= r_over[i];
                r_rem[i+1]  <= ge ? r_rem[i] - shd : r_rem[i];
                r_den[i+1]  <= r_den[i];
                r_q[i+1]    <= n_q;
                r_org[i+1]  <= r_org[i];
                r_dir[i+1]  <= r_dir[i];
            end
        end
    end

    assign t_val = r_over[W-1] ? {1'b0, {QB{1'b1}}} : {1'b0, r_q[W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
            r_vo <= 1'b0;
        end else if (ce) begin
            r_vm <= r_v[W-1];
            r_vo <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_hitm  <= r_hit[W-1];
            r_overm <= r_over[W-1];
            r_orgm  <= r_org[W-1];
            for (int j = 0; j < 3; j++) begin
                r_prod[j] <= r_dir[W-1][j] * t_val;
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            p[j]    = PW'(r_orgm[j]) + PW'(r_prod[j] >>> FRAC_BITS);
            csat[j] = (p[j] > MAXC) || (p[j] < MINC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_hito <= r_hitm;
            r_sato <= r_hitm && (r_overm || csat[0] || csat[1] || csat[2]);
            for (int j = 0; j < 3; j++) begin
                if (!r_hitm) begin
                    r_co[j] <= '0;
                end else if (p[j] > MAXC) begin
                    r_co[j] <= W'(MAXC);
                end else if (p[j] < MINC) begin
                    r_co[j] <= W'(MINC);
                end else begin
                    r_co[j] <= W'(p[j]);
                end
            end
        end
    end

    assign o_res.valid     = r_vo;
    assign o_res.hit       = r_hito;
    assign o_res.hit_x     = r_co[0];
    assign o_res.hit_y     = r_co[1];
    assign o_res.hit_z     = r_co[2];
    assign o_res.saturated = r_sato;
endmodule

[design/ray_plane_intersect_core.sv]
// Top level of the ray/plane intersection core.
// Throughput: one beat per cycle when neither the queue nor the output stalls;
// set by the one-bit-per-stage divider pipeline.
// Front and back stall independently through a 4-entry queue.
// Reset: synchronous active-low i_rst_n clears all valid flags and the queue.
module ray_plane_intersect_core
    import rpi_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rpi_ray_if.sink    i_ray,
    rpi_hit_if.source  o_hit
);
    localparam int W  = COORD_WIDTH;
    localparam int DW = 2*W+2;
    localparam int SW = 2*W+3;
    localparam int QW = 1 + 6*W + SW + DW;

    logic                f_valid, f_ready;
    logic                f_hit;
    logic signed [W-1:0] f_org [3];
    logic signed [W-1:0] f_dir [3];
    logic [SW-1:0]       f_smag;
    logic [DW-1:0]       f_dmag;

    logic                b_valid, b_ready;
    logic [QW-1:0]       q_in, q_out;
    logic signed [W-1:0] b_org [3];
    logic signed [W-1:0] b_dir [3];

    rpi_front #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ray      (i_ray),
        .o_valid    (f_valid),
        .i_ready    (f_ready),
        .o_hit      (f_hit),
        .o_org      (f_org),
        .o_dir      (f_dir),
        .o_side_mag (f_smag),
        .o_den_mag  (f_dmag)
    );

    assign q_in = {f_hit, f_org[0], f_org[1], f_org[2], f_dir[0], f_dir[1], f_dir[2],
                   f_smag, f_dmag};

    rpi_fifo #(.DATA_W(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (q_in),
        .o_valid (b_valid),
        .i_ready (b_ready),
        .o_data  (q_out)
    );

    assign b_org[0] = q_out[QW-2     -: W];
    assign b_org[1] = q_out[QW-2-W   -: W];
    assign b_org[2] = q_out[QW-2-2*W -: W];
    assign b_dir[0] = q_out[QW-2-3*W -: W];
    assign b_dir[1] = q_out[QW-2-4*W -: W];
    assign b_dir[2] = q_out[QW-2-5*W -: W];

    rpi_back #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (b_valid),
        .o_ready    (b_ready),
        .i_hit      (q_out[QW-1]),
        .i_org      (b_org),
        .i_dir      (b_dir),
        .i_side_mag (q_out[SW+DW-1:DW]),
        .i_den_mag  (q_out[DW-1:0]),
        .o_res      (o_hit)
    );
endmodule

[tb/sv/tb_ray_plane_intersect_core.sv]
// Testbench for ray_plane_intersect_core: directed table and random rays checked against a predictor.
`timescale 1ns / 1ps

module tb_ray_plane_intersect_core;
    import rpi_pkg::*;

    localparam int W         = COORD_WIDTH_DEF;
    localparam int F         = FRAC_BITS_DEF;
    localparam int ONE       = 1 << F;
    localparam int N_RANDOM  = 1535;
    localparam int IDLE_MAX  = 14;
    localparam int WDOG_MAX  = 3000;

    typedef logic signed [W-1:0]   coord_t;
    typedef logic signed [127:0]   wide_t;

    typedef struct {
        coord_t o[3];
        coord_t d[3];
        coord_t n[3];
        coord_t off;
    } ray_t;

    typedef struct {
        bit     hit;
        coord_t p[3];
        bit     sat;
    } hit_t;

    typedef struct {
        ray_t r;
        bit   typed;
        hit_t e;
    } row_t;

    logic i_clk;
    logic i_rst_n;

    rpi_ray_if #(.W(W)) ray_ch ();
    rpi_hit_if #(.W(W)) hit_ch ();

    ray_plane_intersect_core #(
        .FRAC_BITS   (F),
        .COORD_WIDTH (W)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ray   (ray_ch),
        .o_hit   (hit_ch)
    );

    hit_t   pending_hits[$];
    row_t   ray_table[$];
    int     fails;
    int     idle_cycles;
    int     stall_left;
    bit     calm;
    bit     done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic wide_t widen(coord_t v);
        wide_t w;
        w = v;
        return w;
    endfunction

    function automatic hit_t predict_hit(ray_t r);
        wide_t       denom, side, lim, t, p;
        logic [127:0] num, dmag, quo;
        hit_t        h;
        h.hit = 1'b0;
        h.sat = 1'b0;
        for (int i = 0; i < 3; i++) h.p[i] = '0;
        denom = '0;
        side  = widen(r.off) <<< F;
        for (int i = 0; i < 3; i++) begin
            denom = denom + widen(r.n[i]) * widen(r.d[i]);
            side  = side + widen(r.n[i]) * widen(r.o[i]);
        end
        if (denom == 0) return h;
        if (side < 0 ? !(denom > 0) : !(denom < 0)) return h;
        h.hit = 1'b1;
        lim   = (wide_t'(1) <<< (W - 1)) - 1;
        num   = (side < 0 ? -side : side) << F;
        dmag  = denom < 0 ? -denom : denom;
        quo   = num / dmag;
        if (quo > lim) begin
            t     = lim;
            h.sat = 1'b1;
        end else begin
            t = quo;
        end
        for (int i = 0; i < 3; i++) begin
            p = widen(r.o[i]) + ((widen(r.d[i]) * t) >>> F);
            if (p < -lim - 1) begin
                p     = -lim - 1;
                h.sat = 1'b1;
            end else if (p > lim) begin
                p     = lim;
                h.sat = 1'b1;
            end
            h.p[i] = p[W-1:0];
        end
        return h;
    endfunction

    function automatic ray_t make_ray(coord_t ox, coord_t oy, coord_t oz,
                                      coord_t dx, coord_t dy, coord_t dz,
                                      coord_t nx, coord_t ny, coord_t nz, coord_t off);
        ray_t r;
        r.o   = '{ox, oy, oz};
        r.d   = '{dx, dy, dz};
        r.n   = '{nx, ny, nz};
        r.off = off;
        return r;
    endfunction

    function automatic row_t make_row(ray_t r, bit typed, bit hit,
                                      coord_t x, coord_t y, coord_t z, bit sat);
        row_t row;
        row.r       = r;
        row.typed   = typed;
        row.e.hit   = hit;
        row.e.p     = '{x, y, z};
        row.e.sat   = sat;
        return row;
    endfunction

    function automatic coord_t small_coord();
        return coord_t'(int'($urandom_range(0, 16 * ONE)) - 8 * ONE);
    endfunction

    function automatic ray_t random_ray();
        ray_t r;
        int   kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            r.o[i] = small_coord();
            r.d[i] = small_coord();
            r.n[i] = small_coord();
        end
        r.off = small_coord();
        if (kind <= 2) begin
            for (int i = 0; i < 3; i++) begin
                r.o[i] = $urandom;
                r.d[i] = $urandom;
                r.n[i] = $urandom;
            end
            r.off = $urandom;
        end else if (kind == 8) begin
            r.n[0] = '0;
            r.n[1] = '0;
            r.d[2] = '0;
        end else if (kind == 9) begin
            r.n[0] = '0;
            r.n[1] = '0;
            r.n[2] = ONE;
            r.off  = -r.o[2];
        end
        return r;
    endfunction

    task automatic send_ray(ray_t r, hit_t e);
        ray_ch.valid          <= 1'b1;
        ray_ch.origin_x       <= r.o[0];
        ray_ch.origin_y       <= r.o[1];
        ray_ch.origin_z       <= r.o[2];
        ray_ch.dir_x          <= r.d[0];
        ray_ch.dir_y          <= r.d[1];
        ray_ch.dir_z          <= r.d[2];
        ray_ch.plane_normal_x <= r.n[0];
        ray_ch.plane_normal_y <= r.n[1];
        ray_ch.plane_normal_z <= r.n[2];
        ray_ch.plane_offset   <= r.off;
        do @(posedge i_clk); while (!ray_ch.ready);
        pending_hits.push_back(e);
        if (!calm) begin
            int gap;
            gap = $urandom_range(0, IDLE_MAX);
            if (gap > 0) begin
                ray_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        ray_t r;
        ray_ch.valid          = 1'b0;
        ray_ch.origin_x       = '0;
        ray_ch.origin_y       = '0;
        ray_ch.origin_z       = '0;
        ray_ch.dir_x          = '0;
        ray_ch.dir_y          = '0;
        ray_ch.dir_z          = '0;
        ray_ch.plane_normal_x = '0;
        ray_ch.plane_normal_y = '0;
        ray_ch.plane_normal_z = '0;
        ray_ch.plane_offset   = '0;
        fails = 0;
        calm  = 1'b0;
        done  = 1'b0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        ray_table.push_back(make_row(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, 0, 0));
        ray_table.push_back(make_row(make_ray(ONE, ONE, ONE, ONE, 0, 0, 0, 0, ONE, -ONE),
                                     1, 0, 0, 0, 0, 0));
        ray_table.push_back(make_row(make_ray(ONE, 2 * ONE, 3 * ONE, 0, 0, -ONE,
                                              0, 0, ONE, -3 * ONE), 1, 1, ONE, 2 * ONE, 3 * ONE, 0));
        ray_table.push_back(make_row(make_ray(ONE, 2 * ONE, 2 * ONE, 0, 0, -ONE, 0, 0, ONE, 0),
                                     1, 1, ONE, 2 * ONE, 0, 0));
        ray_table.push_back(make_row(make_ray(ONE, 2 * ONE, 2 * ONE, 0, 0, ONE, 0, 0, ONE, 0),
                                     1, 0, 0, 0, 0, 0));
        ray_table.push_back(make_row(make_ray(0, 0, -2 * ONE, 0, 0, -ONE, 0, 0, ONE, 0),
                                     1, 0, 0, 0, 0, 0));
        ray_table.push_back(make_row(make_ray(0, 0, -2 * ONE, ONE, 0, ONE, 0, 0, ONE, 0),
                                     1, 1, 2 * ONE, 0, 0, 0));
        ray_table.push_back(make_row(make_ray(0, 0, 32'sh7fff0000, 0, 0, -1, 0, 0, ONE, 0),
                                     0, 0, 0, 0, 0, 0));
        ray_table.push_back(make_row(make_ray({W{1'b1}} >> 1, {W{1'b1}} >> 1, {W{1'b1}} >> 1,
                                              {W{1'b1}} >> 1, {W{1'b1}} >> 1, {W{1'b1}} >> 1,
                                              {W{1'b1}} >> 1, {W{1'b1}} >> 1, {W{1'b1}} >> 1,
                                              {W{1'b1}} >> 1), 0, 0, 0, 0, 0, 0));
        ray_table.push_back(make_row(make_ray(1 << (W - 1), 1 << (W - 1), 1 << (W - 1),
                                              1 << (W - 1), 1 << (W - 1), 1 << (W - 1),
                                              1 << (W - 1), 1 << (W - 1), 1 << (W - 1),
                                              1 << (W - 1)), 0, 0, 0, 0, 0, 0));
        ray_table.push_back(make_row(make_ray(1 << (W - 1), 1 << (W - 1), 1 << (W - 1),
                                              -1, -1, -1, -1, -1, -1, {W{1'b1}} >> 1),
                                     0, 0, 0, 0, 0, 0));
        ray_table.push_back(make_row(make_ray(0, 0, 1 << (W - 1), 1 << (W - 1), -1, 1,
                                              0, 0, {W{1'b1}} >> 1, 1 << (W - 1)),
                                     0, 0, 0, 0, 0, 0));
        ray_table.push_back(make_row(make_ray(-1, -1, -1, {W{1'b1}} >> 1, 1 << (W - 1), -1,
                                              1, 1, 1, 1 << (W - 1)), 0, 0, 0, 0, 0, 0));
        ray_table.push_back(make_row(make_ray(3 * ONE, -ONE, ONE, -ONE, ONE, -2 * ONE,
                                              ONE, ONE, ONE, 0), 0, 0, 0, 0, 0, 0));

        foreach (ray_table[i])
            send_ray(ray_table[i].r,
                     ray_table[i].typed ? ray_table[i].e : predict_hit(ray_table[i].r));

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 200 == 100) calm = ~calm;
            if (i == N_RANDOM / 2) begin
                ray_ch.valid <= 1'b0;
                while (pending_hits.size() != 0) @(posedge i_clk);
            end
            r = random_ray();
            send_ray(r, predict_hit(r));
        end
        ray_ch.valid <= 1'b0;
        calm = 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (2 * W) @(posedge i_clk);
        done = 1'b1;
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hit_ch.ready <= 1'b0;
            stall_left   = 0;
        end else begin
            if (hit_ch.valid && hit_ch.ready) begin
                hit_t e;
                if (pending_hits.size() == 0) begin
                    $error("result beat with no ray outstanding");
                    fails++;
                end else begin
                    e = pending_hits.pop_front();
                    if (hit_ch.hit !== e.hit) begin
                        $error("hit: expected %0d, got %0d", e.hit, hit_ch.hit);
                        fails++;
                    end
                    if (hit_ch.hit_x !== e.p[0]) begin
                        $error("hit_x: expected %0d, got %0d", e.p[0], hit_ch.hit_x);
                        fails++;
                    end
                    if (hit_ch.hit_y !== e.p[1]) begin
                        $error("hit_y: expected %0d, got %0d", e.p[1], hit_ch.hit_y);
                        fails++;
                    end
                    if (hit_ch.hit_z !== e.p[2]) begin
                        $error("hit_z: expected %0d, got %0d", e.p[2], hit_ch.hit_z);
                        fails++;
                    end
                    if (hit_ch.saturated !== e.sat) begin
                        $error("saturated: expected %0d, got %0d", e.sat, hit_ch.saturated);
                        fails++;
                    end
                end
                stall_left = calm ? 0 : $urandom_range(0, IDLE_MAX);
            end
            if (stall_left > 0) begin
                hit_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                hit_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (ray_ch.valid && ray_ch.ready) || (hit_ch.valid && hit_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX && !done) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule
